// ----- src/hbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the HRRN batch scheduler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int unsigned ARR_W   = 16;
    localparam int unsigned BUR_W   = 16;
    localparam int unsigned OTIME_W = 21;
    localparam int unsigned OIDX_W  = 4;

    typedef logic [2:0] t_state;

    localparam t_state S_IDLE = 3'd0;
    localparam t_state S_ADDR = 3'd1;
    localparam t_state S_MUL1 = 3'd2;
    localparam t_state S_MUL2 = 3'd3;
    localparam t_state S_CMP  = 3'd4;
    localparam t_state S_EMIT = 3'd5;

endpackage

// ----- src/hrrn_batch_scheduler.sv -----
// ----------------------------------------------------------------------------
// hrrn_batch_scheduler
// Non-preemptive highest-response-ratio-next batch scheduler.
// ----------------------------------------------------------------------------
// Items are offered on start with arrival, burst and last-job flag; one is
// taken at each clock edge where start is high and busy is low. Items beyond
// MAX_JOBS are dropped, but a last-job flag on a dropped item still launches
// the run. Once the last item is in, busy stays high while the schedule is
// worked out. Every pick scans the n stored jobs through the job RAM's single
// read port: a job that is done, not yet arrived or first found ready passes
// through S_ADDR and S_MUL1; one that is ranked through the shared multiplier
// (two cross products, one compare) also passes through S_MUL2 and S_CMP; then
// S_EMIT issues the pick. An idle gap, including one before the earliest
// arrival, costs one more scan.
// Each pick appears for one cycle on the result ports with o_result_valid;
// the receiver cannot stall. The final pick carries o_last_result; in the same
// cycle the done flags, job count and clock are cleared and busy drops.
// Reset (synchronous, active low) clears control state; the job RAM is not
// cleared and needs no sweep.
// ----------------------------------------------------------------------------
module hrrn_batch_scheduler
    import hbs_pkg::*;
#(
    parameter int unsigned MAX_JOBS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ARR_W-1:0]   i_arrival_time,
    input  logic [BUR_W-1:0]   i_burst_time,
    input  logic               i_last_job,
    output logic               o_result_valid,
    output logic [OIDX_W-1:0]  o_job_index,
    output logic [OTIME_W-1:0] o_start_time,
    output logic [OTIME_W-1:0] o_completion_time,
    output logic [OTIME_W-1:0] o_waiting_time,
    output logic [OTIME_W-1:0] o_turnaround_time,
    output logic               o_last_result
);

    localparam int unsigned IW = $clog2(MAX_JOBS);
    localparam int unsigned CW = $clog2(MAX_JOBS + 1);
    localparam int unsigned TW = ARR_W + CW;
    localparam int unsigned NW = TW + 1;
    localparam int unsigned PW = NW + BUR_W;
    localparam int unsigned RW = ARR_W + BUR_W;

    // control
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_picks, n_picks;
    logic [TW-1:0]       r_time, n_time;
    logic [MAX_JOBS-1:0] r_done, n_done;
    logic                r_found, n_found;
    logic                r_any, n_any;
    logic                r_valid, n_valid;

    // datapath
    logic [IW-1:0]       r_best, n_best;
    logic [ARR_W-1:0]    r_best_arr, n_best_arr;
    logic [BUR_W-1:0]    r_best_bur, n_best_bur;
    logic [ARR_W-1:0]    r_min, n_min;
    logic [PW-1:0]       r_lhs, n_lhs;
    logic [PW-1:0]       r_rhs, n_rhs;

    logic [OIDX_W-1:0]   r_out_idx;
    logic [OTIME_W-1:0]  r_out_start, r_out_fin, r_out_wait, r_out_tat;
    logic                r_out_last;

    // ram
    logic                ram_we;
    logic [IW-1:0]       ram_addr;
    logic [RW-1:0]       ram_rdata;

    logic [ARR_W-1:0]    arr_k;
    logic [BUR_W-1:0]    bur_k;
    logic [NW-1:0]       num_k, num_best;
    logic [NW-1:0]       mul_a;
    logic [BUR_W-1:0]    mul_b;
    logic [PW-1:0]       product;
    logic                k_last, pick_last, better;
    logic [TW-1:0]       finish;
    logic [IW+OIDX_W-1:0] idx_ext;

    hbs_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_arrival_time, i_burst_time}),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign ram_we   = (r_state == S_IDLE) && start && (r_count < CW'(MAX_JOBS));
    assign ram_addr = (r_state == S_IDLE) ? r_count[IW-1:0] : r_k[IW-1:0];

    assign arr_k = ram_rdata[RW-1:BUR_W];
    assign bur_k = (ram_rdata[BUR_W-1:0] == '0) ? BUR_W'(1) : ram_rdata[BUR_W-1:0];

    assign num_k    = {1'b0, r_time} - NW'(arr_k) + NW'(bur_k);
    assign num_best = {1'b0, r_time} - NW'(r_best_arr) + NW'(r_best_bur);

    // shared multiplier: candidate then incumbent cross product
    assign mul_a   = (r_state == S_MUL1) ? num_k : num_best;
    assign mul_b   = (r_state == S_MUL1) ? r_best_bur : bur_k;
    assign product = PW'(mul_a) * PW'(mul_b);

    assign better    = (r_lhs > r_rhs) || ((r_lhs == r_rhs) && (arr_k < r_best_arr));
    assign k_last    = (r_k == r_count - CW'(1));
    assign pick_last = (r_picks == r_count - CW'(1));
    assign finish    = r_time + TW'(r_best_bur);
    assign idx_ext   = {{OIDX_W{1'b0}}, r_best};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_picks    = r_picks;
        n_time     = r_time;
        n_done     = r_done;
        n_found    = r_found;
        n_any      = r_any;
        n_valid    = 1'b0;
        n_best     = r_best;
        n_best_arr = r_best_arr;
        n_best_bur = r_best_bur;
        n_min      = r_min;
        n_lhs      = r_lhs;
        n_rhs      = r_rhs;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (ram_we) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_last_job) begin
                        n_k     = '0;
                        n_picks = '0;
                        n_found = 1'b0;
                        n_any   = 1'b0;
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_state = S_ADDR;
                if (!r_done[r_k[IW-1:0]]) begin
                    if (!r_any || arr_k < r_min) begin
                        n_min = arr_k;
                        n_any = 1'b1;
                    end
                    if (TW'(arr_k) <= r_time) begin
                        if (!r_found) begin
                            n_found    = 1'b1;
                            n_best     = r_k[IW-1:0];
                            n_best_arr = arr_k;
                            n_best_bur = bur_k;
                        end else begin
                            n_lhs   = product;
                            n_state = S_MUL2;
                        end
                    end
                end
                if (n_state == S_ADDR) begin
                    if (k_last) begin
                        n_state = S_EMIT;
                    end else begin
                        n_k = r_k + CW'(1);
                    end
                end
            end
            S_MUL2: begin
                n_rhs   = product;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (better) begin
                    n_best     = r_k[IW-1:0];
                    n_best_arr = arr_k;
                    n_best_bur = bur_k;
                end
                if (k_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_ADDR;
                end
            end
            S_EMIT: begin
                n_k     = '0;
                n_found = 1'b0;
                n_any   = 1'b0;
                n_state = S_ADDR;
                if (r_found) begin
                    n_valid        = 1'b1;
                    n_done[r_best] = 1'b1;
                    n_time         = finish;
                    n_picks        = r_picks + CW'(1);
                    if (pick_last) begin
                        n_done  = '0;
                        n_count = '0;
                        n_time  = '0;
                        n_state = S_IDLE;
                    end
                end else begin
                    // idle gap: jump to earliest pending arrival and rescan
                    n_time = TW'(r_min);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_picks <= '0;
            r_time  <= '0;
            r_done  <= '0;
            r_found <= 1'b0;
            r_any   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_picks <= n_picks;
            r_time  <= n_time;
            r_done  <= n_done;
            r_found <= n_found;
            r_any   <= n_any;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_arr <= n_best_arr;
        r_best_bur <= n_best_bur;
        r_min      <= n_min;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        if (n_valid) begin
            r_out_idx   <= idx_ext[OIDX_W-1:0];
            r_out_start <= OTIME_W'({{OTIME_W{1'b0}}, r_time});
            r_out_fin   <= OTIME_W'({{OTIME_W{1'b0}}, finish});
            r_out_wait  <= OTIME_W'({{OTIME_W{1'b0}}, r_time - TW'(r_best_arr)});
            r_out_tat   <= OTIME_W'({{OTIME_W{1'b0}}, finish - TW'(r_best_arr)});
            r_out_last  <= pick_last;
        end
    end

    assign o_result_valid    = r_valid;
    assign o_job_index       = r_out_idx;
    assign o_start_time      = r_out_start;
    assign o_completion_time = r_out_fin;
    assign o_waiting_time    = r_out_wait;
    assign o_turnaround_time = r_out_tat;
    assign o_last_result     = r_out_last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_done == '0))
        else $error("done flags set while idle");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_EMIT))
        else $error("result outside pick issue");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_result) |-> !busy)
        else $error("still busy after last result");

    a_times_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            (OTIME_W'(o_turnaround_time - o_waiting_time)
             == OTIME_W'(o_completion_time - o_start_time)))
        else $error("waiting and turnaround disagree");

endmodule

// ----- src/hbs_ram.sv -----
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-port RAM, one read a cycle plus an optional write to the same address, registered read.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
